FILE: rtl/bs_pkg.sv
// Shared types, constants and helpers for the Burning Ship escape-time block.
// Used by bs_front, bs_queue, bs_iter and burning_ship_escape_time.
`default_nettype none

package bs_pkg;

	localparam int FRAC_BITS   = 26;
	localparam int Q_W         = 32;
	localparam int COUNT_W     = 10;
	localparam int SHADE_W     = 8;
	localparam int STEP_DIV    = 80;
	localparam int QUEUE_DEPTH = 2;

	// |z|^2 escape bound, 4.0 in Q12.52
	localparam logic [63:0] ESC_LIMIT = 64'h0040_0000_0000_0000;

	localparam logic signed [63:0] Q_MAX = 64'sh0000_0000_7FFF_FFFF;
	localparam logic signed [63:0] Q_MIN = -64'sh0000_0000_8000_0000;

	typedef struct packed {
		logic signed [Q_W-1:0] re;
		logic signed [Q_W-1:0] im;
	} coord_t;

	typedef enum logic [3:0] {
		CFG_CENTER_RE = 4'd0,
		CFG_CENTER_IM = 4'd1,
		CFG_ZOOM      = 4'd2,
		CFG_MAX_ITER  = 4'd3
	} cfg_index_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_MUL,
		F_DIV,
		F_PUSH
	} front_state_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_MUL,
		B_UPD,
		B_DONE
	} iter_state_t;

	function automatic logic signed [Q_W-1:0] sat_q(input logic signed [63:0] v);
		logic signed [Q_W-1:0] r;
		if (v > Q_MAX) begin
			r = Q_MAX[Q_W-1:0];
		end else if (v < Q_MIN) begin
			r = Q_MIN[Q_W-1:0];
		end else begin
			r = v[Q_W-1:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/bs_front.sv
// Front end: takes a pixel item, maps it to the point c in Q6.26.
// Offset times zoom, then a divide by 80 in two reciprocal-multiply steps per axis.
// Uses bs_pkg.
`default_nettype none

module bs_front import bs_pkg::*; #(
	parameter int SCREEN_WIDTH  = 1280,
	parameter int SCREEN_HEIGHT = 720
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [10:0]           pixel_col,
	input  wire logic [9:0]            pixel_row,
	input  wire logic signed [Q_W-1:0] center_real,
	input  wire logic signed [Q_W-1:0] center_imag,
	input  wire logic [30:0]           zoom,
	output logic                       push_valid,
	input  wire logic                  push_ready,
	output coord_t                     push_data
);

	localparam int HALF_W = SCREEN_WIDTH / 2;
	localparam int HALF_H = SCREEN_HEIGHT / 2;
	localparam int OFF_W  = 13;
	localparam int PROD_W = OFF_W + 32;
	localparam int MAG_W  = PROD_W - 1;
	// magnitude over 16, then over 5 in two 20-bit digits
	localparam int DVD_W  = MAG_W - 4;
	localparam int HALF_Q = 20;
	localparam int LO_W   = HALF_Q + 3;

	// floor(n / 5) for any 32-bit n
	function automatic logic [31:0] div5(input logic [31:0] n);
		logic [63:0] p;
		p = 64'(n) * 64'h0000_0000_CCCC_CCCD;
		return 32'(p[63:34]);
	endfunction

	front_state_t state_q, state_d;

	logic [10:0]        col_q;
	logic [9:0]         row_q;
	logic               step_q;
	logic [DVD_W-1:0]   dvd_re_q, dvd_im_q;
	logic [LO_W-1:0]    lo_re_q, lo_im_q;
	logic               neg_re_q, neg_im_q;

	logic signed [OFF_W-1:0]  off_re, off_im;
	logic signed [31:0]       zoom_s;
	logic signed [PROD_W-1:0] prod_re, prod_im;
	logic [PROD_W-1:0]        negp_re, negp_im;
	logic [DVD_W-1:0]         mag_re, mag_im;
	logic [31:0]              hq_re, hq_im, lq_re, lq_im;
	logic [2:0]               hr_re, hr_im;
	logic signed [DVD_W:0]    qs_re, qs_im, val_re, val_im;
	logic signed [63:0]       sum_re, sum_im;

	assign off_re  = $signed({2'b00, col_q}) - $signed(OFF_W'(HALF_W));
	assign off_im  = $signed({3'b000, row_q}) - $signed(OFF_W'(HALF_H));
	assign zoom_s  = $signed({1'b0, zoom});
	assign prod_re = off_re * zoom_s;
	assign prod_im = off_im * zoom_s;
	assign negp_re = -prod_re;
	assign negp_im = -prod_im;
	assign mag_re  = prod_re[PROD_W-1] ? negp_re[MAG_W-1:4] : prod_re[MAG_W-1:4];
	assign mag_im  = prod_im[PROD_W-1] ? negp_im[MAG_W-1:4] : prod_im[MAG_W-1:4];

	// first step: high digit over 5 and its remainder; second step: low digit
	assign hq_re = div5(32'(dvd_re_q[DVD_W-1:HALF_Q]));
	assign hq_im = div5(32'(dvd_im_q[DVD_W-1:HALF_Q]));
	assign hr_re = 3'(dvd_re_q[DVD_W-1:HALF_Q] - 20'({hq_re[17:0], 2'b00} + hq_re[19:0]));
	assign hr_im = 3'(dvd_im_q[DVD_W-1:HALF_Q] - 20'({hq_im[17:0], 2'b00} + hq_im[19:0]));
	assign lq_re = div5(32'(lo_re_q));
	assign lq_im = div5(32'(lo_im_q));

	// truncation toward zero: divide the magnitude, then restore the sign
	assign qs_re  = $signed({1'b0, dvd_re_q});
	assign qs_im  = $signed({1'b0, dvd_im_q});
	assign val_re = neg_re_q ? -qs_re : qs_re;
	assign val_im = neg_im_q ? -qs_im : qs_im;
	assign sum_re = 64'(val_re) + 64'(center_real);
	assign sum_im = 64'(val_im) + 64'(center_imag);

	assign push_data.re = sat_q(sum_re);
	assign push_data.im = sat_q(sum_im);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		in_ready   = 1'b0;
		push_valid = 1'b0;
		unique case (state_q)
			F_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = F_MUL;
				end
			end
			F_MUL: begin
				state_d = F_DIV;
			end
			F_DIV: begin
				if (step_q) begin
					state_d = F_PUSH;
				end
			end
			F_PUSH: begin
				push_valid = 1'b1;
				if (push_ready) begin
					state_d = F_IDLE;
				end
			end
			default: begin
				state_d = F_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			F_IDLE: begin
				if (in_valid) begin
					col_q <= pixel_col;
					row_q <= pixel_row;
				end
			end
			F_MUL: begin
				dvd_re_q <= mag_re;
				dvd_im_q <= mag_im;
				neg_re_q <= prod_re[PROD_W-1];
				neg_im_q <= prod_im[PROD_W-1];
				step_q   <= 1'b0;
			end
			F_DIV: begin
				if (!step_q) begin
					dvd_re_q <= {hq_re[HALF_Q-1:0], HALF_Q'(0)};
					dvd_im_q <= {hq_im[HALF_Q-1:0], HALF_Q'(0)};
					lo_re_q  <= {hr_re, dvd_re_q[HALF_Q-1:0]};
					lo_im_q  <= {hr_im, dvd_im_q[HALF_Q-1:0]};
				end else begin
					dvd_re_q <= dvd_re_q + DVD_W'(lq_re);
					dvd_im_q <= dvd_im_q + DVD_W'(lq_im);
				end
				step_q <= 1'b1;
			end
			default: begin
			end
		endcase
	end

	a_div_steps: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == F_DIV && step_q) |=> (state_q == F_PUSH))
		else $error("divider did not finish after its second step");

	a_accept_to_mul: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == F_MUL))
		else $error("accepted item did not enter the multiply step");

endmodule

`default_nettype wire

FILE: rtl/bs_queue.sv
// Two-entry queue of mapped points between the front end and the iterator.
// Uses bs_pkg for coord_t and the depth.
`default_nettype none

module bs_queue import bs_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   push_valid,
	output logic        push_ready,
	input  wire coord_t push_data,
	output logic        pop_valid,
	input  wire logic   pop_ready,
	output coord_t      pop_data
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	coord_t             mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               do_push, do_pop;

	assign push_ready = cnt_q != CNT_W'(QUEUE_DEPTH);
	assign pop_valid  = cnt_q != '0;
	assign pop_data   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(QUEUE_DEPTH))
		else $error("queue fill count above depth");

	a_cnt_track: assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && !do_pop) |=> (cnt_q == $past(cnt_q) + 1'b1))
		else $error("queue count missed a push");

endmodule

`default_nettype wire

FILE: rtl/bs_iter.sv
// Back end: runs the Burning Ship iteration for one point and holds the result.
// Each iteration is a square step, then an escape test and update. Uses bs_pkg.
`default_nettype none

module bs_iter import bs_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic [COUNT_W-1:0] max_iterations,
	input  wire logic               pop_valid,
	output logic                    pop_ready,
	input  wire coord_t             pop_data,
	output logic                    result_valid,
	input  wire logic               result_ready,
	output logic [COUNT_W-1:0]      escape_count,
	output logic [SHADE_W-1:0]      shade
);

	iter_state_t state_q, state_d;

	coord_t                  c_q;
	logic signed [Q_W-1:0]   zr_q, zi_q;
	logic [COUNT_W-1:0]      count_q;
	logic [63:0]             sr_s1, si_s1, pr_s1;
	logic                    res_valid_q;
	logic [COUNT_W-1:0]      res_count_q;
	logic [SHADE_W-1:0]      res_shade_q;

	logic [Q_W-1:0]          ar, ai;
	logic [63:0]             mag_sum;
	logic                    escaped;
	logic signed [63:0]      diff, twice, re_n, im_n;
	logic                    load_res;
	logic [8:0]              ten_x;
	logic [SHADE_W-1:0]      shade_n;

	assign ar = zr_q[Q_W-1] ? (~zr_q + 1'b1) : zr_q;
	assign ai = zi_q[Q_W-1] ? (~zi_q + 1'b1) : zi_q;

	assign mag_sum = sr_s1 + si_s1;
	assign escaped = mag_sum >= ESC_LIMIT;
	// without escape both squares are below 2^54, so both stay positive as signed values
	assign diff  = $signed(sr_s1) - $signed(si_s1);
	assign twice = $signed({pr_s1[62:0], 1'b0});
	assign re_n  = (diff >>> FRAC_BITS) + 64'(c_q.re);
	assign im_n  = (twice >>> FRAC_BITS) + 64'(c_q.im);

	// shade reaches zero from 26 iterations on
	assign ten_x   = {count_q[4:0], 3'b000} + {2'b00, count_q[4:0], 1'b0};
	assign shade_n = (count_q > COUNT_W'(25)) ? '0 : SHADE_W'(9'd255 - ten_x);

	assign result_valid = res_valid_q;
	assign escape_count = res_count_q;
	assign shade        = res_shade_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		pop_ready = 1'b0;
		load_res  = 1'b0;
		unique case (state_q)
			B_IDLE: begin
				pop_ready = 1'b1;
				if (pop_valid) begin
					state_d = B_MUL;
				end
			end
			B_MUL: begin
				if (count_q == max_iterations) begin
					state_d = B_DONE;
				end else begin
					state_d = B_UPD;
				end
			end
			B_UPD: begin
				state_d = escaped ? B_DONE : B_MUL;
			end
			B_DONE: begin
				if (!res_valid_q || result_ready) begin
					load_res = 1'b1;
					state_d  = B_IDLE;
				end
			end
			default: begin
				state_d = B_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				if (pop_valid) begin
					c_q     <= pop_data;
					zr_q    <= '0;
					zi_q    <= '0;
					count_q <= '0;
				end
			end
			B_MUL: begin
				sr_s1 <= 64'(ar) * 64'(ar);
				si_s1 <= 64'(ai) * 64'(ai);
				pr_s1 <= 64'(ar) * 64'(ai);
			end
			B_UPD: begin
				if (!escaped) begin
					zr_q    <= sat_q(re_n);
					zi_q    <= sat_q(im_n);
					count_q <= count_q + 1'b1;
				end
			end
			default: begin
			end
		endcase
		if (load_res) begin
			res_count_q <= count_q;
			res_shade_q <= shade_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (load_res) begin
			res_valid_q <= 1'b1;
		end else if (result_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	a_start_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_IDLE && pop_valid) |=> (count_q == '0 && zr_q == '0 && zi_q == '0))
		else $error("iteration did not start from zero");

	a_upd_after_mul: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_UPD) |-> ($past(state_q) == B_MUL))
		else $error("update step without a square step");

endmodule

`default_nettype wire

FILE: rtl/burning_ship_escape_time.sv
// Burning Ship escape-time evaluator, top level: config registers and the
// front end / queue / iterator chain. Uses bs_pkg, bs_front, bs_queue, bs_iter.
//
// Usage:
//   pixel_valid/pixel_ready carry one item (pixel_col, pixel_row). The front end
//   maps it to c = (pixel - screen center) * zoom / 80 + center; c and center are Q6.26, zoom unsigned Q5.26.
//   result_valid/result_ready carry escape_count and shade for each item, in order.
//   cfg_valid/cfg_ready write register cfg_index (0 center_real, 1 center_imag,
//   2 zoom, 3 max_iterations) with cfg_data; other indexes are dropped.
//   cfg_ready is always high. Write config only while no item is in flight.
// Flow:
//   Front end: per item it accepts, multiplies, takes two divide steps for the
//   divide by 80 and pushes; it takes a new item only after the push is taken.
//   Iterator: each iteration is a square step and an update step (escape test);
//   an item stopped by the limit ends on a square step, one that escapes on an update.
//   A two-entry queue lets the front end map the next items while the iterator
//   works; the result register lets the iterator start the next item while a
//   result waits. A stalled receiver holds the result; items back up in order.
// Reset: registers return to center 0, zoom 4.0, max_iterations 64; no items held.
`default_nettype none

module burning_ship_escape_time import bs_pkg::*; #(
	parameter int SCREEN_WIDTH  = 1280,
	parameter int SCREEN_HEIGHT = 720
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               pixel_valid,
	output logic                    pixel_ready,
	input  wire logic [10:0]        pixel_col,
	input  wire logic [9:0]         pixel_row,
	output logic                    result_valid,
	input  wire logic               result_ready,
	output logic [COUNT_W-1:0]      escape_count,
	output logic [SHADE_W-1:0]      shade,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [3:0]         cfg_index,
	input  wire logic [31:0]        cfg_data
);

	logic signed [Q_W-1:0] center_real_q, center_imag_q;
	logic [30:0]           zoom_q;
	logic [COUNT_W-1:0]    max_iter_q;

	logic   fq_valid, fq_ready, qb_valid, qb_ready;
	coord_t fq_data, qb_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_real_q <= '0;
			center_imag_q <= '0;
			zoom_q        <= 31'h1000_0000;
			max_iter_q    <= COUNT_W'(64);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_CENTER_RE: center_real_q <= $signed(cfg_data);
				CFG_CENTER_IM: center_imag_q <= $signed(cfg_data);
				CFG_ZOOM:      zoom_q        <= cfg_data[30:0];
				CFG_MAX_ITER:  max_iter_q    <= cfg_data[COUNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	bs_front #(
		.SCREEN_WIDTH  (SCREEN_WIDTH),
		.SCREEN_HEIGHT (SCREEN_HEIGHT)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (pixel_valid),
		.in_ready    (pixel_ready),
		.pixel_col   (pixel_col),
		.pixel_row   (pixel_row),
		.center_real (center_real_q),
		.center_imag (center_imag_q),
		.zoom        (zoom_q),
		.push_valid  (fq_valid),
		.push_ready  (fq_ready),
		.push_data   (fq_data)
	);

	bs_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fq_valid),
		.push_ready (fq_ready),
		.push_data  (fq_data),
		.pop_valid  (qb_valid),
		.pop_ready  (qb_ready),
		.pop_data   (qb_data)
	);

	bs_iter u_iter (
		.clk            (clk),
		.arst_n         (arst_n),
		.max_iterations (max_iter_q),
		.pop_valid      (qb_valid),
		.pop_ready      (qb_ready),
		.pop_data       (qb_data),
		.result_valid   (result_valid),
		.result_ready   (result_ready),
		.escape_count   (escape_count),
		.shade          (shade)
	);

endmodule

`default_nettype wire
